// ===== hw/rtl/tcw_pkg.sv =====
// Text console writer package: shared field widths, character codes and the
// work item that travels from the front end to the back end through the queue.
// No dependencies.
package tcw_pkg;

	localparam int CHAR_W       = 8;
	localparam int ATTR_W       = 8;
	localparam int READ_ADDR_W  = 12;
	localparam int COL_W        = 8;
	localparam int CURSOR_IDX_W = 11;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [COL_W-1:0]  COL_LAST   = 8'hFF;

	// Classified operation of one command.
	typedef enum logic [1:0] {
		OP_READ,
		OP_NEWLINE,
		OP_PUT
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [CHAR_W-1:0]      char_code;
		logic [ATTR_W-1:0]      attribute;
		logic [READ_ADDR_W-1:0] read_address;
	} work_t;

	// Status reported by the back end to the front end.
	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

// ===== hw/rtl/tcw_if.sv =====
// Valid/ready channel interfaces of the text console writer: the command
// channel and the result channel. Depends on tcw_pkg for field widths.
interface tcw_cmd_if import tcw_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   command;
	logic [CHAR_W-1:0]      char_code;
	logic [ATTR_W-1:0]      attribute;
	logic [READ_ADDR_W-1:0] read_address;

	modport source (output valid, command, char_code, attribute, read_address, input ready);
	modport sink (input valid, command, char_code, attribute, read_address, output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CHAR_W-1:0]       read_data;
	logic                    char_stored;
	logic                    cursor_moved;
	logic [CURSOR_IDX_W-1:0] cursor_index;

	modport source (output valid, read_data, char_stored, cursor_moved, cursor_index,
		input ready);
	modport sink (input valid, read_data, char_stored, cursor_moved, cursor_index,
		output ready);
endinterface

// ===== hw/rtl/text_console_writer_unit.sv =====
// Top level of the text console writer: front end, work queue and back end.
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_fifo and tcw_back.
//
// The block prints characters into a text-mode screen store of STORE_BYTES
// bytes that holds character/attribute pairs, ROW_BYTES bytes to a row.
// Commands arrive as transactions on the cmd channel: a put command either
// writes a character with its attribute at the cursor or, for a newline,
// moves to the next row, scrolling the screen up when it is past LAST_ROW.
// A read command returns one stored byte. Every command produces exactly
// one result transaction on the res channel, in command order.
//
// The front end classifies commands into a two-entry queue, so it keeps
// taking transactions while the back end works or while a result waits for
// the receiver. The back end owns the store, which has one byte write port,
// so a printed character is written a byte at a time: character, attribute,
// trailing space, attribute. With the back end idle, a newline or a dropped
// character is answered in the next cycle, a read from ST_RD_WAIT, where the
// stored byte is registered, and a printed character after its last write.
// The back end takes the next command in the cycle after its result is
// taken, never while a result waits, so it handles one command at a time.
// A newline on the last row also starts a scroll, which moves every row up
// a byte at a time and blanks the bottom row; the next command waits in the queue.
//
// After reset the back end clears the whole store, one byte a cycle, and
// cmd.ready stays low meanwhile.
// When the receiver stalls, the result is held in the output register and
// the back end stops taking work; the queue fills and then cmd.ready drops.
module text_console_writer_unit import tcw_pkg::*; #(
	parameter int ROW_BYTES   = 160,
	parameter int LAST_ROW    = 24,
	parameter int STORE_BYTES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	tcw_cmd_if.sink   cmd,
	tcw_res_if.source res
);

	// Handshake between the front end and the work queue.
	logic       push_valid;
	logic       push_ready;
	work_t      push_data;

	// Handshake between the work queue and the back end.
	logic       pop_valid;
	logic       pop_ready;
	work_t      pop_data;

	// The back end tells the front end when the store clear is running.
	back_stat_t stat;

	tcw_front u_front (
		.cmd       (cmd),
		.stat      (stat),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	tcw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	tcw_back #(
		.ROW_BYTES  (ROW_BYTES),
		.LAST_ROW   (LAST_ROW),
		.STORE_BYTES(STORE_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.stat     (stat),
		.res      (res)
	);

endmodule

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/tcw_fifo.sv =====
// Short work queue between the front end and the back end.
// Depends on tcw_pkg for the work item type and the queue depth.
module tcw_fifo import tcw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  work_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output work_t pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	work_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/tcw_front.sv =====
// Front end of the text console writer: takes command transactions and
// classifies them into queue work items. Depends on tcw_pkg and tcw_if.
module tcw_front import tcw_pkg::*; (
	tcw_cmd_if.sink    cmd,
	input  back_stat_t stat,
	output logic       push_valid,
	input  logic       push_ready,
	output work_t      push_data
);

	// Nothing is taken while the back end is clearing the screen store.
	assign cmd.ready  = push_ready && !stat.clearing;
	assign push_valid = cmd.valid && !stat.clearing;

	always_comb begin
		push_data.char_code    = cmd.char_code;
		push_data.attribute    = cmd.attribute;
		push_data.read_address = cmd.read_address;
		if (cmd.command) begin
			push_data.op = OP_READ;
		end else if (cmd.char_code == CH_NEWLINE) begin
			push_data.op = OP_NEWLINE;
		end else begin
			push_data.op = OP_PUT;
		end
	end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// Back end of the text console writer: cursor state, the screen store RAM and
// the sequencer for reads, character writes, scrolling and the reset clear.
// Depends on tcw_pkg, tcw_if and tcw_ram.
module tcw_back import tcw_pkg::*; #(
	parameter int ROW_BYTES   = 160,
	parameter int LAST_ROW    = 24,
	parameter int STORE_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  work_t      pop_data,
	output back_stat_t stat,
	tcw_res_if.source  res
);

	localparam int AW        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int SPAN      = LAST_ROW * ROW_BYTES + ROW_BYTES + 512;
	localparam int TOP1      = (SPAN > STORE_BYTES) ? SPAN : STORE_BYTES;
	localparam int TOP2      = (TOP1 > 4096) ? TOP1 : 4096;
	localparam int OFS_W     = $clog2(TOP2 + 1);
	localparam int ROW_W     = $clog2(LAST_ROW + 1);
	localparam int ROW_CELLS = ROW_BYTES / 2;
	localparam int SCROLL_N  = ROW_BYTES * LAST_ROW;

	localparam logic [OFS_W-1:0] STORE_O  = OFS_W'(STORE_BYTES);
	localparam logic [OFS_W-1:0] ROW_O    = OFS_W'(ROW_BYTES);
	localparam logic [OFS_W-1:0] CELLS_O  = OFS_W'(ROW_CELLS);
	localparam logic [OFS_W-1:0] SCROLL_O = OFS_W'(SCROLL_N);
	localparam logic [ROW_W-1:0] LAST_R   = ROW_W'(LAST_ROW);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_WAIT,
		ST_PUT_ATTR,
		ST_PUT_SP,
		ST_PUT_SPA,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_SCR_CLR
	} state_t;

	state_t                  state_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [OFS_W-1:0]        ofs_q;
	logic [OFS_W-1:0]        idx_q;
	logic [ATTR_W-1:0]       attr_q;
	logic                    src_ok_q;
	logic                    res_valid_q;
	logic [CHAR_W-1:0]       res_data_q;
	logic                    res_stored_q;
	logic                    res_moved_q;
	logic [CURSOR_IDX_W-1:0] res_index_q;

	logic [OFS_W-1:0]  put_ofs;
	logic [OFS_W-1:0]  cell_idx;
	logic [OFS_W-1:0]  rd_ofs;
	logic [OFS_W-1:0]  scr_src;
	logic [OFS_W-1:0]  clr_dst;
	logic              put_ok;
	logic              rd_ok;
	logic              take;
	logic              ram_we;
	logic [OFS_W-1:0]  ram_waddr;
	logic [CHAR_W-1:0] ram_wdata;
	logic              ram_re;
	logic [OFS_W-1:0]  ram_raddr;
	logic [CHAR_W-1:0] ram_rdata;

	assign put_ofs  = OFS_W'(row_q) * ROW_O + OFS_W'({col_q, 1'b0});
	assign cell_idx = OFS_W'(row_q) * CELLS_O + OFS_W'(col_q);
	assign rd_ofs   = OFS_W'(pop_data.read_address);
	assign scr_src  = idx_q + ROW_O;
	assign clr_dst  = SCROLL_O + idx_q;
	assign put_ok   = (put_ofs < STORE_O) && (col_q != COL_LAST);
	assign rd_ok    = (rd_ofs < STORE_O);

	assign pop_ready     = (state_q == ST_IDLE) && !res_valid_q;
	assign take          = pop_valid && pop_ready;
	assign stat.clearing = (state_q == ST_CLEAR);

	assign res.valid        = res_valid_q;
	assign res.read_data    = res_data_q;
	assign res.char_stored  = res_stored_q;
	assign res.cursor_moved = res_moved_q;
	assign res.cursor_index = res_index_q;

	// Store access for each step; addresses past the store end are dropped.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
			end
			ST_IDLE: begin
				if (take && pop_data.op == OP_READ) begin
					ram_re    = rd_ok;
					ram_raddr = rd_ofs;
				end else if (take && pop_data.op == OP_PUT) begin
					ram_we    = put_ok;
					ram_waddr = put_ofs;
					ram_wdata = pop_data.char_code;
				end
			end
			ST_PUT_ATTR, ST_PUT_SPA: begin
				ram_we    = (ofs_q < STORE_O);
				ram_waddr = ofs_q;
				ram_wdata = attr_q;
			end
			ST_PUT_SP: begin
				ram_we    = (ofs_q < STORE_O);
				ram_waddr = ofs_q;
				ram_wdata = CH_SPACE;
			end
			ST_RD_WAIT: begin
			end
			ST_SCR_RD: begin
				ram_re    = (scr_src < STORE_O);
				ram_raddr = scr_src;
			end
			ST_SCR_WR: begin
				ram_we    = (idx_q < STORE_O);
				ram_waddr = idx_q;
				ram_wdata = src_ok_q ? ram_rdata : '0;
			end
			ST_SCR_CLR: begin
				ram_we    = (clr_dst < STORE_O);
				ram_waddr = clr_dst;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			col_q        <= '0;
			row_q        <= '0;
			ofs_q        <= '0;
			idx_q        <= '0;
			attr_q       <= '0;
			src_ok_q     <= 1'b0;
			res_valid_q  <= 1'b0;
			res_data_q   <= '0;
			res_stored_q <= 1'b0;
			res_moved_q  <= 1'b0;
			res_index_q  <= '0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == STORE_O - 1'b1) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (take) begin
						res_data_q   <= '0;
						res_stored_q <= 1'b0;
						res_moved_q  <= 1'b0;
						res_index_q  <= '0;
						unique case (pop_data.op)
							OP_READ: begin
								if (rd_ok) begin
									state_q <= ST_RD_WAIT;
								end else begin
									res_valid_q <= 1'b1;
								end
							end
							OP_NEWLINE: begin
								col_q       <= '0;
								res_valid_q <= 1'b1;
								if (row_q == LAST_R) begin
									idx_q   <= '0;
									state_q <= ST_SCR_RD;
								end else begin
									row_q <= row_q + 1'b1;
								end
							end
							OP_PUT: begin
								if (put_ok) begin
									ofs_q   <= put_ofs + 1'b1;
									attr_q  <= pop_data.attribute;
									state_q <= ST_PUT_ATTR;
								end else begin
									res_valid_q <= 1'b1;
								end
							end
							default: begin
								res_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_RD_WAIT: begin
					res_data_q  <= ram_rdata;
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_PUT_ATTR: begin
					col_q   <= col_q + 1'b1;
					ofs_q   <= ofs_q + 1'b1;
					state_q <= ST_PUT_SP;
				end
				ST_PUT_SP: begin
					if (ofs_q >= STORE_O) begin
						res_stored_q <= 1'b1;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						ofs_q   <= ofs_q + 1'b1;
						state_q <= ST_PUT_SPA;
					end
				end
				ST_PUT_SPA: begin
					res_stored_q <= 1'b1;
					res_moved_q  <= 1'b1;
					res_index_q  <= cell_idx[CURSOR_IDX_W-1:0];
					res_valid_q  <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_SCR_RD: begin
					src_ok_q <= (scr_src < STORE_O);
					state_q  <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					if (idx_q == SCROLL_O - 1'b1) begin
						idx_q   <= '0;
						state_q <= ST_SCR_CLR;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCR_RD;
					end
				end
				ST_SCR_CLR: begin
					if (idx_q == ROW_O - 1'b1) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	tcw_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(STORE_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr[AW-1:0]),
		.rdata(ram_rdata)
	);

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// Port-level checker for the text console writer and its bind to the top level.
// Depends on tcw_pkg for the result field widths.
module tcw_checker import tcw_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    cmd_valid,
	input logic                    cmd_ready,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic [CHAR_W-1:0]       res_read_data,
	input logic                    res_char_stored,
	input logic                    res_cursor_moved,
	input logic [CURSOR_IDX_W-1:0] res_cursor_index
);

	// Transactions accepted on cmd whose result has not yet been taken.
	logic [2:0] pending_q;
	logic       cmd_fire;
	logic       res_fire;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign res_fire = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd_fire && !res_fire) begin
			pending_q <= pending_q + 1'b1;
		end else if (res_fire && !cmd_fire) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A result never shows up without a command behind it.
	a_no_orphan_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 3'd0)
		else $error("result offered with no pending command");

	// Two queue entries plus one in the back end bound the work in flight.
	a_full_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q >= 3'd3 |-> !cmd_ready)
		else $error("command taken with the block full");

	// Right after reset the store is being cleared, so nothing is taken.
	a_clear_after_reset: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> !cmd_ready)
		else $error("command ready during the store clear");

	// A stalled result keeps its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_read_data)
			&& $stable(res_char_stored) && $stable(res_cursor_moved)
			&& $stable(res_cursor_index))
		else $error("stalled result changed");

	// The cursor only moves after a character was stored, and such a result carries zero read data.
	a_moved_needs_store: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_cursor_moved |-> res_char_stored && res_read_data == '0)
		else $error("cursor move without a stored character");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_read_data   (res.read_data),
	.res_char_stored (res.char_stored),
	.res_cursor_moved(res.cursor_moved),
	.res_cursor_index(res.cursor_index)
);

// ===== sim/text_console_writer_unit_tb.sv =====
// Self-checking testbench for text_console_writer_unit: drives put and read
// commands, predicts each result from a model of the screen store and cursor.
// Depends on tcw_pkg, tcw_if and the text_console_writer_unit RTL.
`timescale 1ns / 100ps

module text_console_writer_unit_tb;
	import tcw_pkg::*;

	localparam int ROW_BYTES   = 160;
	localparam int LAST_ROW    = 24;
	localparam int STORE_BYTES = 4096;

	// Command encoding on the cmd channel.
	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Random traffic volume, and the number of newlines that may scroll the
	// screen. Each scroll walks the rows up to the last one byte by byte, so
	// the count is capped to keep the run short.
	localparam int RANDOM_ITEMS = 1030;
	localparam int TOTAL_ITEMS  = RANDOM_ITEMS + 21;
	localparam int SCROLL_LIMIT = 40;
	localparam int MAX_REPORTS  = 10;
	localparam int DRAIN_CYCLES = 20;
	// Clearing pass plus every allowed scroll plus every item at its slowest,
	// then taken several times over.
	localparam int LIMIT_CYCLES = 3_000_000;

	typedef struct packed {
		logic                   command;
		logic [CHAR_W-1:0]      char_code;
		logic [ATTR_W-1:0]      attribute;
		logic [READ_ADDR_W-1:0] read_address;
	} console_cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0]       read_data;
		logic                    char_stored;
		logic                    cursor_moved;
		logic [CURSOR_IDX_W-1:0] cursor_index;
	} console_res_t;

	// Screen model: keeps its own copy of the store and the cursor, works out
	// the result of every accepted command and checks results in order.
	class console_scoreboard;
		logic [CHAR_W-1:0] screen [STORE_BYTES];
		int unsigned       column;
		int unsigned       row;
		console_res_t      pending [$];
		int                failures;
		int                results_seen;

		function new();
			foreach (screen[i])
				screen[i] = '0;
			column = 0;
			row = 0;
			failures = 0;
			results_seen = 0;
		endfunction

		function logic [CHAR_W-1:0] stored_byte(int unsigned addr);
			return (addr < STORE_BYTES) ? screen[addr] : '0;
		endfunction

		// Writes past the end of the store are dropped.
		function void write_byte(int unsigned addr, logic [CHAR_W-1:0] value);
			if (addr < STORE_BYTES)
				screen[addr] = value;
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("MISMATCH at %0t: %s", $time, msg);
		endfunction

		function void note_command(console_cmd_t c);
			console_res_t r;
			int unsigned  spot;
			r = '0;
			if (c.command == CMD_READ) begin
				r.read_data = stored_byte(c.read_address);
			end else if (c.char_code == CH_NEWLINE) begin
				column = 0;
				row++;
				if (row > LAST_ROW) begin
					// Scroll: every row moves up by one, the bottom row is blanked.
					for (int unsigned i = 0; i < ROW_BYTES * LAST_ROW; i++)
						write_byte(i, stored_byte(i + ROW_BYTES));
					for (int unsigned i = 0; i < ROW_BYTES; i++)
						write_byte(ROW_BYTES * LAST_ROW + i, '0);
					row = LAST_ROW;
				end
			end else begin
				spot = row * ROW_BYTES + column * 2;
				// A full store or a saturated column drops the character.
				if (spot < STORE_BYTES && column < COL_LAST) begin
					write_byte(spot, c.char_code);
					write_byte(spot + 1, c.attribute);
					column++;
					r.char_stored = 1'b1;
					spot = row * ROW_BYTES + column * 2;
					if (spot < STORE_BYTES) begin
						write_byte(spot, CH_SPACE);
						write_byte(spot + 1, c.attribute);
						r.cursor_moved = 1'b1;
						r.cursor_index = CURSOR_IDX_W'(row * (ROW_BYTES / 2) + column);
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(console_res_t got);
			console_res_t want;
			results_seen++;
			if (pending.size() == 0) begin
				flag($sformatf("result %0d arrived with nothing expected", results_seen));
				return;
			end
			want = pending.pop_front();
			if (got.read_data !== want.read_data || got.char_stored !== want.char_stored ||
					got.cursor_moved !== want.cursor_moved ||
					got.cursor_index !== want.cursor_index)
				flag($sformatf({"result %0d: expected data %02h stored %b moved %b index %0d,",
					" got data %02h stored %b moved %b index %0d"}, results_seen,
					want.read_data, want.char_stored, want.cursor_moved, want.cursor_index,
					got.read_data, got.char_stored, got.cursor_moved, got.cursor_index));
		endfunction
	endclass

	bit   clk = 1'b0;
	logic arst_n;

	tcw_cmd_if cmd ();
	tcw_res_if res ();

	text_console_writer_unit #(
		.ROW_BYTES  (ROW_BYTES),
		.LAST_ROW   (LAST_ROW),
		.STORE_BYTES(STORE_BYTES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.res   (res)
	);

	console_scoreboard board = new();

	// Idling rates in percent; the sender changes them as the run moves
	// through its phases, the receiver reads them every cycle.
	int gap_pct     = 0;
	int stall_pct   = 0;
	int sent        = 0;
	int scrolls_left = SCROLL_LIMIT;

	always #5 clk = ~clk;

	// Receiver: checks every accepted result transaction and stalls at random.
	initial res.ready = 1'b0;
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			board.check_result('{read_data: res.read_data, char_stored: res.char_stored,
				cursor_moved: res.cursor_moved, cursor_index: res.cursor_index});
		res.ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	// Offers one command and returns at the edge where it is accepted. Valid
	// is left high so that back-to-back transactions see no bubble; a newline
	// that would scroll past the budget is turned into a read instead.
	task automatic send_command(input console_cmd_t c);
		int idle_phase;
		if (c.command == CMD_PUT && c.char_code == CH_NEWLINE && board.row == LAST_ROW) begin
			if (scrolls_left == 0)
				c.command = CMD_READ;
			else
				scrolls_left--;
		end
		// Four idling phases of equal length: none, sender gaps, receiver
		// stalls, then both at a light rate.
		idle_phase = (sent * 4) / TOTAL_ITEMS;
		case (idle_phase)
			0: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct = 45;
				stall_pct = 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct = 45;
			end
			default: begin
				gap_pct = 13;
				stall_pct = 13;
			end
		endcase
		while ($urandom_range(0, 99) < gap_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid        <= 1'b1;
		cmd.command      <= c.command;
		cmd.char_code    <= c.char_code;
		cmd.attribute    <= c.attribute;
		cmd.read_address <= c.read_address;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		board.note_command(c);
		sent++;
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] attr);
		send_command('{command: CMD_PUT, char_code: ch, attribute: attr,
			read_address: READ_ADDR_W'($urandom_range(0, STORE_BYTES - 1))});
	endtask

	task automatic read_byte(input int unsigned addr);
		send_command('{command: CMD_READ, char_code: CHAR_W'($urandom_range(0, 255)),
			attribute: ATTR_W'($urandom_range(0, 255)), read_address: READ_ADDR_W'(addr)});
	endtask

	// Any byte but the newline code.
	function automatic logic [CHAR_W-1:0] printable_char();
		int unsigned v;
		v = $urandom_range(0, 254);
		if (v >= CH_NEWLINE)
			v++;
		return CHAR_W'(v);
	endfunction

	// Half the time the cursor row, where recent writes landed; otherwise anywhere,
	// or the bottom row and the tail of the store past it.
	function automatic int unsigned read_target();
		int unsigned pick;
		pick = $urandom_range(0, 3);
		if (pick < 2)
			return board.row * ROW_BYTES + $urandom_range(0, ROW_BYTES - 1);
		else if (pick == 2)
			return $urandom_range(0, STORE_BYTES - 1);
		else
			return $urandom_range(ROW_BYTES * LAST_ROW, STORE_BYTES - 1);
	endfunction

	initial begin
		int              kind;
		int              count;
		logic [ATTR_W-1:0] line_attr;
		bit              first_line;
		bit              bottom_line_done;

		arst_n           <= 1'b0;
		cmd.valid        <= 1'b0;
		cmd.command      <= CMD_PUT;
		cmd.char_code    <= '0;
		cmd.attribute    <= '0;
		cmd.read_address <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The store has been cleared, so both ends read zero.
		read_byte(0);
		read_byte(STORE_BYTES - 1);
		// Character and attribute extremes; each leaves a space at the cursor.
		put_char(8'h00, 8'hFF);
		put_char(8'hFF, 8'h00);
		put_char(8'h41, 8'h5A);
		for (int i = 0; i < 8; i++)
			read_byte(i);
		// A newline moves to the next row; print a plain space there.
		put_char(CH_NEWLINE, 8'h00);
		put_char(CH_SPACE, 8'h07);
		read_byte(ROW_BYTES);
		read_byte(ROW_BYTES + 2);
		read_byte(ROW_BYTES + 3);
		// A read whose char_code holds the newline code must not move the cursor.
		send_command('{command: CMD_READ, char_code: CH_NEWLINE, attribute: 8'hFF,
			read_address: READ_ADDR_W'(ROW_BYTES + 1)});
		put_char(CH_NEWLINE, 8'hFF);
		put_char(CH_NEWLINE, 8'h00);

		// Random part, built from episodes that look like console output. The
		// first episode is a line long enough to saturate the column; the first
		// time the cursor sits on the bottom row, a line runs off the end of
		// the store, which covers both the dropped trailing space and the
		// dropped character.
		first_line = 1'b1;
		bottom_line_done = 1'b0;
		while (sent < TOTAL_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (first_line || (board.row == LAST_ROW && !bottom_line_done))
				kind = 50;
			line_attr = ATTR_W'($urandom_range(0, 255));
			if (kind < 50) begin
				// Short line with occasional reads back, ended by a newline.
				count = $urandom_range(1, 10);
				for (int k = 0; k < count; k++) begin
					put_char(printable_char(), ($urandom_range(0, 3) == 0) ?
						ATTR_W'($urandom_range(0, 255)) : line_attr);
					if ($urandom_range(0, 3) == 0)
						read_byte(read_target());
				end
				put_char(CH_NEWLINE, line_attr);
			end else if (kind < 53) begin
				// Long line: past 255 columns on the first one, past the end of
				// the store on the bottom row.
				if (first_line)
					count = $urandom_range(256, 262);
				else
					count = $urandom_range(130, 170);
				if (board.row == LAST_ROW)
					bottom_line_done = 1'b1;
				first_line = 1'b0;
				for (int k = 0; k < count; k++)
					put_char(printable_char(), line_attr);
				read_byte(STORE_BYTES - 1);
				read_byte(STORE_BYTES - 2);
				put_char(CH_NEWLINE, line_attr);
			end else if (kind < 68) begin
				// Blank lines; on the bottom row each one scrolls while the scroll budget lasts.
				count = $urandom_range(1, 4);
				for (int k = 0; k < count; k++)
					put_char(CH_NEWLINE, ATTR_W'($urandom_range(0, 255)));
			end else if (kind < 85) begin
				count = $urandom_range(1, 8);
				for (int k = 0; k < count; k++)
					read_byte(read_target());
			end else begin
				// Noise: any command with any field values.
				count = $urandom_range(1, 10);
				for (int k = 0; k < count; k++)
					send_command('{command: ($urandom_range(0, 1) == 0) ? CMD_PUT : CMD_READ,
						char_code: ($urandom_range(0, 7) == 0) ? CH_NEWLINE :
							CHAR_W'($urandom_range(0, 255)),
						attribute: ATTR_W'($urandom_range(0, 255)),
						read_address: READ_ADDR_W'($urandom_range(0, STORE_BYTES - 1))});
			end
		end
		// Drop valid at the edge of the last acceptance so it is not taken twice.
		cmd.valid <= 1'b0;

		// Let every expected result arrive, then watch a little longer for
		// anything extra.
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.failures == 0 && board.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("TEST FAILED");
		$finish;
	end

endmodule
